// ===== rtl/hzp_pkg.sv =====
// ----------------------------------------------------------------------------
// hzp_pkg
// Shared types and constants of the max-depth pyramid builder.
// ----------------------------------------------------------------------------
package hzp_pkg;

  localparam int unsigned DepthW    = 30;
  localparam int unsigned LevelW    = 3;
  localparam int unsigned CoordW    = 9;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned QuadW     = 6;

  localparam int unsigned MaxTilesX = 64;
  localparam int unsigned MaxTilesY = 64;
  localparam int unsigned ResetTiles = 64;

  localparam int unsigned ColW     = (MaxTilesX > 1) ? $clog2(MaxTilesX) : 1;
  localparam int unsigned RowW     = (MaxTilesY > 1) ? $clog2(MaxTilesY) : 1;
  localparam int unsigned AcrossW  = $clog2(MaxTilesX + 1);
  localparam int unsigned DownW    = $clog2(MaxTilesY + 1);

  // one beat per pyramid level 1..4
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned CntW     = 3;

  localparam int unsigned ResetAcross = (ResetTiles < MaxTilesX) ? ResetTiles : MaxTilesX;
  localparam int unsigned ResetDown   = (ResetTiles < MaxTilesY) ? ResetTiles : MaxTilesY;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TILES_ACROSS = 1'b0,
    REG_TILES_DOWN   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DepthW-1:0] depth;
  } texel_t;

  // walk position and running maxima
  typedef struct packed {
    logic [QuadW-1:0]  quad;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [DepthW-1:0] max2;
    logic [DepthW-1:0] max3;
    logic [DepthW-1:0] max4;
  } walk_t;

endpackage

// ===== rtl/hzp_quad_reduce.sv =====
// ----------------------------------------------------------------------------
// hzp_quad_reduce
// Reduces one quad to its level 1..4 texels and advances the tile walk.
// ----------------------------------------------------------------------------
module hzp_quad_reduce (
  input  logic [hzp_pkg::DepthW-1:0]  depth_tl_i,
  input  logic [hzp_pkg::DepthW-1:0]  depth_tr_i,
  input  logic [hzp_pkg::DepthW-1:0]  depth_bl_i,
  input  logic [hzp_pkg::DepthW-1:0]  depth_br_i,
  input  logic [hzp_pkg::AcrossW-1:0] across_i,
  input  logic [hzp_pkg::DownW-1:0]   down_i,
  input  hzp_pkg::walk_t              walk_i,
  output hzp_pkg::walk_t              walk_o,
  output hzp_pkg::texel_t             texel_o [hzp_pkg::NumSlots],
  output logic [hzp_pkg::CntW-1:0]    count_o
);
  import hzp_pkg::*;

  logic [DepthW-1:0] max_top, max_bot, m1;
  logic [DepthW-1:0] max2, max3, max4;
  logic [2:0]        qx, qy;
  logic [QuadW-1:0]  q;
  logic [ColW:0]     col_inc;
  logic [RowW:0]     row_inc;
  logic              end2, end3, end4;

  assign q  = walk_i.quad;
  // Z order: even bits are the column, odd bits the row
  assign qx = {q[4], q[2], q[0]};
  assign qy = {q[5], q[3], q[1]};

  assign max_top = (depth_tl_i > depth_tr_i) ? depth_tl_i : depth_tr_i;
  assign max_bot = (depth_bl_i > depth_br_i) ? depth_bl_i : depth_br_i;
  assign m1      = (max_top > max_bot) ? max_top : max_bot;

  assign max2 = (q[1:0] == 2'd0) ? m1 : ((walk_i.max2 > m1) ? walk_i.max2 : m1);
  assign max3 = (q[3:0] == 4'd0) ? m1 : ((walk_i.max3 > m1) ? walk_i.max3 : m1);
  assign max4 = (q == '0)        ? m1 : ((walk_i.max4 > m1) ? walk_i.max4 : m1);

  assign end2 = (q[1:0] == 2'b11);
  assign end3 = (q[3:0] == 4'b1111);
  assign end4 = (q == '1);

  assign count_o = end4 ? CntW'(4) : end3 ? CntW'(3) : end2 ? CntW'(2) : CntW'(1);

  always_comb begin
    texel_o[0] = '{level: LevelW'(1), x: CoordW'({walk_i.col, qx}),
                   y: CoordW'({walk_i.row, qy}), depth: m1};
    texel_o[1] = '{level: LevelW'(2), x: CoordW'({walk_i.col, qx[2:1]}),
                   y: CoordW'({walk_i.row, qy[2:1]}), depth: max2};
    texel_o[2] = '{level: LevelW'(3), x: CoordW'({walk_i.col, qx[2]}),
                   y: CoordW'({walk_i.row, qy[2]}), depth: max3};
    texel_o[3] = '{level: LevelW'(4), x: CoordW'(walk_i.col),
                   y: CoordW'(walk_i.row), depth: max4};
  end

  assign col_inc = {1'b0, walk_i.col} + 1'b1;
  assign row_inc = {1'b0, walk_i.row} + 1'b1;

  always_comb begin
    walk_o      = walk_i;
    walk_o.max2 = max2;
    walk_o.max3 = max3;
    walk_o.max4 = max4;
    walk_o.quad = q + 1'b1;
    if (end4) begin
      if (32'(col_inc) >= 32'(across_i)) begin
        walk_o.col = '0;
        if (32'(row_inc) >= 32'(down_i)) begin
          walk_o.row = '0;
        end else begin
          walk_o.row = row_inc[RowW-1:0];
        end
      end else begin
        walk_o.col = col_inc[ColW-1:0];
      end
    end
  end

endmodule

// ===== rtl/hiz_max_depth_pyramid.sv =====
// ----------------------------------------------------------------------------
// hiz_max_depth_pyramid
// Max-depth pyramid builder: level-0 quads in, level 1..4 texels out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one 2x2 level-0 quad per
//   beat, tiles of 16x16 pixels in raster order, Z order inside a tile.
//   Output channel (out_valid_o/out_ready_i) carries one texel per beat:
//   every quad gives a level-1 texel, every 4th also a level-2, every 16th
//   a level-3 and every 64th a level-4 texel, in level order; last_o marks
//   the final texel of a quad.
//   Config channel (cfg_valid_i/cfg_ready_o) writes tiles_across / tiles_down;
//   it is always ready. Write only while the block is idle.
// Timing: first texel of a quad shows in the cycle after the input beat.
// Flow: a quad occupies the output register until all of its texels
//   (1 to 4, 85/64 on average) have left; the next quad is taken in the
//   cycle its predecessor's last texel leaves, so single-texel quads stream
//   at one per cycle while out_ready_i stays high.
// Reset: walk goes to tile (0,0), quad 0; both tile counts go to 64.
// Stall: while out_ready_i is low the texel holds and in_ready_o drops.
// ----------------------------------------------------------------------------
module hiz_max_depth_pyramid (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hzp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hzp_pkg::CfgW-1:0]     cfg_data_i,
  // quad input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [hzp_pkg::DepthW-1:0]   depth_top_left_i,
  input  logic [hzp_pkg::DepthW-1:0]   depth_top_right_i,
  input  logic [hzp_pkg::DepthW-1:0]   depth_bottom_left_i,
  input  logic [hzp_pkg::DepthW-1:0]   depth_bottom_right_i,
  // texel output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hzp_pkg::LevelW-1:0]   mip_level_o,
  output logic [hzp_pkg::CoordW-1:0]   texel_x_o,
  output logic [hzp_pkg::CoordW-1:0]   texel_y_o,
  output logic [hzp_pkg::DepthW-1:0]   max_depth_o,
  output logic                         last_o
);
  import hzp_pkg::*;

  // tile counts, held already clamped to 1..max
  logic [AcrossW-1:0] across_q, across_d;
  logic [DownW-1:0]   down_q, down_d;

  walk_t walk_q, walk_next;

  // result buffer: slot k holds the level k+1 texel of the current quad
  texel_t            slot_q [NumSlots];
  texel_t            slot_new [NumSlots];
  logic [CntW-1:0]   cnt_q, cnt_new;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic              busy_q, busy_d;

  logic in_fire, out_fire, on_last;

  // ---- config ----
  assign cfg_ready_o = 1'b1;

  always_comb begin
    across_d = across_q;
    down_d   = down_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TILES_ACROSS: begin
          if (cfg_data_i == '0)                        across_d = AcrossW'(1);
          else if (32'(cfg_data_i) > MaxTilesX)        across_d = AcrossW'(MaxTilesX);
          else                                         across_d = AcrossW'(cfg_data_i);
        end
        REG_TILES_DOWN: begin
          if (cfg_data_i == '0)                        down_d = DownW'(1);
          else if (32'(cfg_data_i) > MaxTilesY)        down_d = DownW'(MaxTilesY);
          else                                         down_d = DownW'(cfg_data_i);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= AcrossW'(ResetAcross);
      down_q   <= DownW'(ResetDown);
    end else begin
      across_q <= across_d;
      down_q   <= down_d;
    end
  end

  // ---- reduction of one quad ----
  hzp_quad_reduce u_reduce (
    .depth_tl_i (depth_top_left_i),
    .depth_tr_i (depth_top_right_i),
    .depth_bl_i (depth_bottom_left_i),
    .depth_br_i (depth_bottom_right_i),
    .across_i   (across_q),
    .down_i     (down_q),
    .walk_i     (walk_q),
    .walk_o     (walk_next),
    .texel_o    (slot_new),
    .count_o    (cnt_new)
  );

  // ---- handshake ----
  assign on_last    = ({1'b0, idx_q} == (cnt_q - 1'b1));
  assign out_fire   = busy_q && out_ready_i;
  // take a new quad when the buffer is empty or drains this cycle
  assign in_ready_o = !busy_q || (out_fire && on_last);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (in_fire) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (out_fire) begin
      if (on_last) busy_d = 1'b0;
      else         idx_d  = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
      busy_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= CntW'(1);
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (in_fire) begin
        walk_q <= walk_next;
        cnt_q  <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_q <= slot_new;
    end
  end

  // ---- output ----
  assign out_valid_o = busy_q;
  assign mip_level_o = slot_q[idx_q].level;
  assign texel_x_o   = slot_q[idx_q].x;
  assign texel_y_o   = slot_q[idx_q].y;
  assign max_depth_o = slot_q[idx_q].depth;
  assign last_o      = on_last;

endmodule
